// File: rtl/srlm_pkg.sv
// Shared constants and types for the stereo RMS level meter.
// No dependencies; every other file imports this package.
package srlm_pkg;

  localparam int SampleBits = 16;
  localparam int MaxFrames  = 4096;
  localparam int CountW     = 13;               // holds 0..MaxFrames
  localparam int SquareW    = 2 * SampleBits;   // one exact square
  localparam int SumW       = 43;               // sum of up to MaxFrames squares
  localparam int RootW      = SampleBits;       // floor sqrt of the mean
  localparam int IterW      = 6;                // counts up to SumW - 1
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;

  // One frame handed from the front end to the back end.
  typedef struct packed {
    logic signed [SampleBits-1:0] mono;
    logic                         last;
    logic [SumW-1:0]              sum_l;
    logic [SumW-1:0]              sum_r;
    logic [CountW-1:0]            count;
  } job_t;

endpackage

// File: rtl/srlm_in_if.sv
// Input stream channel: one stereo frame per transfer.
// Depends on srlm_pkg for the sample width.
interface srlm_in_if;
  import srlm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] left_sample;
  logic signed [SampleBits-1:0] right_sample;
  logic                         last_frame;

  modport source (output valid, output left_sample, output right_sample,
                  output last_frame, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input last_frame, output ready);
endinterface

// File: rtl/srlm_out_if.sv
// Output stream channel: mono sample plus optional buffer levels.
// Depends on srlm_pkg for the sample width.
interface srlm_out_if;
  import srlm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] mono_sample;
  logic                         levels_valid;
  logic [SampleBits-1:0]        rms_left;
  logic [SampleBits-1:0]        rms_right;

  modport source (output valid, output mono_sample, output levels_valid,
                  output rms_left, output rms_right, input ready);
  modport sink   (input valid, input mono_sample, input levels_valid,
                  input rms_left, input rms_right, output ready);
endinterface

// File: rtl/srlm_front.sv
// Front end: takes frames, forms the downmix, squares and accumulates.
// Depends on srlm_pkg and srlm_in_if.
module srlm_front import srlm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  srlm_in_if.sink in_i,
  input  logic   push_ready_i,
  output logic   push_o,
  output job_t   job_o
);

  logic                         s1_v_q;
  logic signed [SampleBits-1:0] s1_mono_q;
  logic                         s1_last_q;
  logic [SquareW-1:0]           s1_sql_q, s1_sqr_q;
  logic [CountW-1:0]            s1_cnt_q;
  logic [CountW-1:0]            frames_q, cnt_next;
  logic [SumW-1:0]              suml_q, sumr_q, suml_add, sumr_add;
  logic                         accept, s1_move, add_en;
  logic signed [SampleBits:0]   pair_sum;
  logic signed [SquareW-1:0]    prod_l, prod_r;

  assign s1_move     = s1_v_q && push_ready_i;
  assign in_i.ready  = !s1_v_q || push_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign add_en      = frames_q < CountW'(MaxFrames);   // saturate on long buffers
  assign cnt_next    = frames_q + CountW'(add_en);
  assign pair_sum    = (SampleBits+1)'(in_i.left_sample) + (SampleBits+1)'(in_i.right_sample);
  assign prod_l      = in_i.left_sample * in_i.left_sample;
  assign prod_r      = in_i.right_sample * in_i.right_sample;
  assign suml_add    = suml_q + SumW'(s1_sql_q);
  assign sumr_add    = sumr_q + SumW'(s1_sqr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      frames_q <= '0;
      suml_q   <= '0;
      sumr_q   <= '0;
    end else begin
      if (accept) begin
        s1_v_q   <= 1'b1;
        frames_q <= in_i.last_frame ? '0 : cnt_next;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        suml_q <= s1_last_q ? '0 : suml_add;
        sumr_q <= s1_last_q ? '0 : sumr_add;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mono_q <= pair_sum[SampleBits:1];   // arithmetic shift, floor
      s1_last_q <= in_i.last_frame;
      s1_sql_q  <= add_en ? SquareW'(prod_l) : '0;
      s1_sqr_q  <= add_en ? SquareW'(prod_r) : '0;
      s1_cnt_q  <= cnt_next;
    end
  end

  assign push_o      = s1_move;
  assign job_o.mono  = s1_mono_q;
  assign job_o.last  = s1_last_q;
  assign job_o.sum_l = suml_add;
  assign job_o.sum_r = sumr_add;
  assign job_o.count = s1_cnt_q;

endmodule

// File: rtl/srlm_queue.sv
// Short FIFO of jobs between the front and back ends.
// Depends on srlm_pkg.
module srlm_queue import srlm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// File: rtl/srlm_back.sv
// Back end: bit-serial mean (divide) and root, then the output register.
// Depends on srlm_pkg and srlm_out_if.
module srlm_back import srlm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       pop_o,
  srlm_out_if.source out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSqrt = 2'd2;
  localparam logic [1:0] StDone = 2'd3;
  localparam int RemW = RootW + 2;

  logic [1:0]              state_q;
  logic [IterW-1:0]        iter_q;
  logic [CountW-1:0]       div_q;
  logic [SumW-1:0]         dql_q, dqr_q;      // dividend in, quotient out, then root input
  logic [CountW-1:0]       reml_q, remr_q;
  logic [RemW-1:0]         srl_q, srr_q;
  logic [RootW-1:0]        rootl_q, rootr_q;
  logic signed [SampleBits-1:0] mono_q;

  logic                    out_v_q, out_lv_q;
  logic signed [SampleBits-1:0] out_mono_q;
  logic [SampleBits-1:0]   out_rl_q, out_rr_q;
  logic                    out_free;
  logic                    out_load;

  logic [CountW:0]         dtl, dtr;
  logic                    dgl, dgr;
  logic [RemW-1:0]         stl, str, sdl, sdr;
  logic                    sgl, sgr;

  assign out_free = !out_v_q || out_o.ready;
  assign pop_o    = (state_q == StIdle) && job_valid_i && out_free;
  // output register takes a plain frame on pop, a last frame once its levels are done
  assign out_load = (pop_o && !job_i.last) || ((state_q == StDone) && out_free);

  // restoring divide step
  assign dtl = {reml_q, dql_q[SumW-1]};
  assign dtr = {remr_q, dqr_q[SumW-1]};
  assign dgl = dtl >= {1'b0, div_q};
  assign dgr = dtr >= {1'b0, div_q};

  // digit-by-digit root step, two input bits per step
  assign stl = {srl_q[RemW-3:0], dql_q[2*RootW-1 -: 2]};
  assign str = {srr_q[RemW-3:0], dqr_q[2*RootW-1 -: 2]};
  assign sdl = {rootl_q, 2'b01};
  assign sdr = {rootr_q, 2'b01};
  assign sgl = stl >= sdl;
  assign sgr = str >= sdr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      iter_q  <= '0;
    end else begin
      if (out_load)         out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (pop_o) begin
            iter_q <= '0;
            if (job_i.last) state_q <= StDiv;
          end
        end
        StDiv: begin
          if (iter_q == IterW'(SumW - 1)) begin
            iter_q  <= '0;
            state_q <= StSqrt;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        StSqrt: begin
          iter_q <= iter_q + 1'b1;
          if (iter_q == IterW'(RootW - 1)) state_q <= StDone;
        end
        StDone: begin
          if (out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (pop_o) begin
          mono_q <= job_i.mono;
          dql_q  <= job_i.sum_l;
          dqr_q  <= job_i.sum_r;
          div_q  <= job_i.count;
          reml_q <= '0;
          remr_q <= '0;
          srl_q  <= '0;
          srr_q  <= '0;
          rootl_q <= '0;
          rootr_q <= '0;
          if (!job_i.last) begin
            out_mono_q <= job_i.mono;
            out_lv_q   <= 1'b0;
            out_rl_q   <= '0;
            out_rr_q   <= '0;
          end
        end
      end
      StDiv: begin
        reml_q <= dgl ? CountW'(dtl - {1'b0, div_q}) : CountW'(dtl);
        remr_q <= dgr ? CountW'(dtr - {1'b0, div_q}) : CountW'(dtr);
        if (iter_q == IterW'(SumW - 1) && div_q == '0) begin
          // a zero count gives level zero
          dql_q <= '0;
          dqr_q <= '0;
        end else begin
          dql_q <= {dql_q[SumW-2:0], dgl};
          dqr_q <= {dqr_q[SumW-2:0], dgr};
        end
      end
      StSqrt: begin
        srl_q   <= sgl ? stl - sdl : stl;
        srr_q   <= sgr ? str - sdr : str;
        rootl_q <= {rootl_q[RootW-2:0], sgl};
        rootr_q <= {rootr_q[RootW-2:0], sgr};
        dql_q   <= dql_q << 2;
        dqr_q   <= dqr_q << 2;
      end
      StDone: begin
        if (out_free) begin
          out_mono_q <= mono_q;
          out_lv_q   <= 1'b1;
          out_rl_q   <= rootl_q;
          out_rr_q   <= rootr_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = out_v_q;
  assign out_o.mono_sample  = out_mono_q;
  assign out_o.levels_valid = out_lv_q;
  assign out_o.rms_left     = out_rl_q;
  assign out_o.rms_right    = out_rr_q;

endmodule

// File: rtl/stereo_rms_level_meter.sv
// Stereo RMS level meter, top level. Ordinary frame: front stage, queue, then output
// register, one per cycle unless the output stalls or a last frame holds the back end
// (43-step serial divide, 16-step serial root); the 4-entry queue keeps the front going.
// Reset (rst_ni low, asynchronous) clears sums, frame count, queue and both valid flags.
// Depends on srlm_pkg, srlm_in_if, srlm_out_if, srlm_front, srlm_queue, srlm_back.
module stereo_rms_level_meter import srlm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  srlm_in_if.sink    in_i,
  srlm_out_if.source out_o
);

  // Front end: downmix plus square and accumulate.
  // It pushes one job per frame; a last frame carries the finished sums and count.
  job_t push_job, head_job;
  logic push, pop, q_full, q_empty;

  srlm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_ready_i (!q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // Job queue decouples accumulation from the long divide/root on buffer end.
  srlm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: passes plain frames straight to the output register,
  // runs mean and root for a last frame before its transfer.
  srlm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (!q_empty),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !pop)
    else $error("queue pop while empty");

  a_levels_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.levels_valid) |-> (out_o.rms_left == '0 && out_o.rms_right == '0))
    else $error("levels nonzero on a plain frame");

  a_push_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> $past(in_i.valid) || $past(push) || $past(q_full))
    else $error("push without a frame in flight");

endmodule

// File: tb/srlm_level_checker.sv
// Scoreboard for the stereo RMS level meter: watches both stream channels,
// predicts each result from the accepted frames and compares field by field.
// Depends on srlm_pkg, srlm_in_if and srlm_out_if.
module srlm_level_checker import srlm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  srlm_in_if          in_mon,
  srlm_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic signed [SampleBits-1:0] mono;
    logic                         levels;
    logic [RootW-1:0]             rms_l;
    logic [RootW-1:0]             rms_r;
  } meter_out_t;

  meter_out_t        meter_out_q[$];
  logic [SumW-1:0]   left_energy;
  logic [SumW-1:0]   right_energy;
  logic [CountW-1:0] frames_in_buffer;

  // Digit-by-digit integer square root, floor.
  function automatic logic [RootW-1:0] floor_root(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[RootW-1:0];
  endfunction

  // Advances the buffer energies by one frame and returns the result it causes.
  task automatic meter_frame(input logic signed [SampleBits-1:0] l_smp,
                             input logic signed [SampleBits-1:0] r_smp,
                             input logic last, output meter_out_t res);
    logic signed [SampleBits:0] pair_sum;
    longint                     l_sq;
    longint                     r_sq;
    longint unsigned            l_mean;
    longint unsigned            r_mean;
    pair_sum = l_smp + r_smp;
    res.mono = pair_sum[SampleBits:1];   // arithmetic halving, floor
    l_sq = longint'(l_smp) * longint'(l_smp);
    r_sq = longint'(r_smp) * longint'(r_smp);
    // count saturates; frames past the cap are ignored
    if (frames_in_buffer < MaxFrames) begin
      left_energy      = left_energy + SumW'(l_sq);
      right_energy     = right_energy + SumW'(r_sq);
      frames_in_buffer = frames_in_buffer + 1'b1;
    end
    res.levels = last;
    res.rms_l  = '0;
    res.rms_r  = '0;
    if (last) begin
      if (frames_in_buffer != 0) begin
        l_mean    = 64'(left_energy) / 64'(frames_in_buffer);
        r_mean    = 64'(right_energy) / 64'(frames_in_buffer);
        res.rms_l = floor_root(l_mean);
        res.rms_r = floor_root(r_mean);
      end
      left_energy      = '0;
      right_energy     = '0;
      frames_in_buffer = '0;
    end
  endtask

  function automatic void check_field(input string field, input longint exp_v,
                                      input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    meter_out_t fresh;
    meter_out_t oldest;
    if (!rst_ni) begin
      meter_out_q.delete();
      left_energy      = '0;
      right_energy     = '0;
      frames_in_buffer = '0;
    end else begin
      // input first: a frame and its own result never share an edge anyway
      if (in_mon.valid && in_mon.ready) begin
        meter_frame(in_mon.left_sample, in_mon.right_sample, in_mon.last_frame, fresh);
        meter_out_q = {meter_out_q, fresh};
      end
      if (out_mon.valid && out_mon.ready) begin
        if (meter_out_q.size() == 0) begin
          $error("unexpected result transfer: mono_sample %0d", $signed(out_mon.mono_sample));
          fail_count_o++;
        end else begin
          oldest = meter_out_q.pop_front();
          check_field("mono_sample", $signed(oldest.mono), $signed(out_mon.mono_sample));
          check_field("levels_valid", oldest.levels, out_mon.levels_valid);
          check_field("rms_left", oldest.rms_l, out_mon.rms_left);
          check_field("rms_right", oldest.rms_r, out_mon.rms_right);
        end
      end
    end
    pending_o = meter_out_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for stereo_rms_level_meter: clock, reset, frame stimulus,
// random back-pressure and the verdict. Depends on srlm_pkg, both stream
// interfaces, the meter RTL and srlm_level_checker.
module tb_top;
  import srlm_pkg::*;

  // Slowest legal run: ~4.9k frames, each paying a long source gap, a long
  // sink stall and a level computation; CycleLimit leaves room for that.
  localparam int unsigned CycleLimit  = 5_000_000;
  localparam int unsigned DrainCycles = 100;    // > one last-frame latency
  localparam int unsigned RandomGoal  = 700;
  localparam int unsigned LongBuffer  = MaxFrames + 5;
  localparam int unsigned HoldPeriod  = 5000;   // sink hold-off cadence
  localparam int unsigned HoldPhase   = 1500;
  localparam int unsigned HoldLength  = 400;

  localparam logic signed [SampleBits-1:0] FullNeg = -(2 ** (SampleBits - 1));
  localparam logic signed [SampleBits-1:0] FullPos = 2 ** (SampleBits - 1) - 1;

  typedef enum int unsigned {SmpFull, SmpEdge, SmpQuiet, SmpTone} sample_kind_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames_sent;
  int unsigned cycle_count;
  bit          gapless;

  logic signed [SampleBits-1:0] tone_l;
  logic signed [SampleBits-1:0] tone_r;

  srlm_in_if  in_ch ();
  srlm_out_if out_ch ();

  stereo_rms_level_meter u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  srlm_level_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SampleBits-1:0] draw_sample(input sample_kind_e kind,
      input logic signed [SampleBits-1:0] tone);
    logic signed [SampleBits-1:0] v;
    case (kind)
      SmpFull:  v = SampleBits'($urandom);
      SmpEdge: begin
        case ($urandom_range(0, 4))
          0:       v = FullNeg;
          1:       v = FullPos;
          2:       v = -1;
          3:       v = 1;
          default: v = 0;
        endcase
      end
      SmpQuiet: v = SampleBits'(int'($urandom_range(0, 512)) - 256);
      default:  v = tone + SampleBits'(int'($urandom_range(0, 64)) - 32);
    endcase
    return v;
  endfunction

  // Offers one frame, starting and ending on a falling edge. Valid stays high
  // across back-to-back transfers; during a gap the payload carries junk.
  task automatic send_frame(input logic signed [SampleBits-1:0] l_smp,
                            input logic signed [SampleBits-1:0] r_smp,
                            input logic last);
    int unsigned idle;
    idle = gapless ? 0 : pick_gap();
    if (idle != 0) begin
      in_ch.valid        <= 1'b0;
      in_ch.left_sample  <= SampleBits'($urandom);
      in_ch.right_sample <= SampleBits'($urandom);
      in_ch.last_frame   <= 1'($urandom);
      repeat (idle) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l_smp;
    in_ch.right_sample <= r_smp;
    in_ch.last_frame   <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    frames_sent++;
  endtask

  // Sink side: alternating ready bursts and stalls, plus a periodic long
  // hold-off so the meter's internal queue fills and it stalls its input.
  initial begin : sink_side
    int unsigned rx_cycles;
    int unsigned hold_left;
    int unsigned phase_left;
    bit          phase_ready;
    rx_cycles   = 0;
    hold_left   = 0;
    phase_left  = 0;
    phase_ready = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycles++;
      if (hold_left != 0) begin
        hold_left--;
      end else if (rx_cycles % HoldPeriod == HoldPhase) begin
        hold_left = HoldLength;
      end else if (phase_left == 0) begin
        phase_ready = !phase_ready;
        if (phase_ready) begin
          // some long bursts give stretches with no stalls at all
          phase_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 40);
        end else begin
          phase_left = pick_gap();
        end
      end else begin
        phase_left--;
      end
      out_ch.ready <= (hold_left == 0) && phase_ready;
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : source_side
    sample_kind_e kind_l;
    sample_kind_e kind_r;
    int unsigned  buf_len;
    int unsigned  roll;
    int unsigned  goal;
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    in_ch.last_frame   = 1'b0;
    frames_sent        = 0;
    gapless            = 1'b0;
    tone_l             = '0;
    tone_r             = '0;
    rst_ni             = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames.
    // One-frame buffers: full-scale negative gives 0x8000, full-scale positive
    // gives 32767, silence gives 0, a one-LSB frame gives 1.
    send_frame(FullNeg, FullNeg, 1'b1);
    send_frame(FullPos, FullPos, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b1);
    send_frame(-16'sd1, 16'sd1, 1'b1);
    // Downmix rounding toward minus infinity, opposite extremes.
    send_frame(FullNeg, FullPos, 1'b0);
    send_frame(FullPos, FullNeg, 1'b0);
    send_frame(-16'sd1, 16'sd0, 1'b0);
    send_frame(16'sd1, 16'sd0, 1'b0);
    send_frame(-16'sd1, -16'sd2, 1'b0);
    send_frame(16'sd3, 16'sd0, 1'b0);
    send_frame(-16'sd3, 16'sd0, 1'b1);
    // Mixed buffer with every sample bit toggling.
    send_frame(16'sh5555, -16'sh2aab, 1'b0);
    send_frame(-16'sh5556, 16'sh2aaa, 1'b0);
    send_frame(16'sd12345, -16'sd23456, 1'b0);
    send_frame(16'sd100, -16'sd100, 1'b1);
    // Back-to-back one-frame buffers with unequal channels.
    gapless = 1'b1;
    send_frame(FullPos, FullNeg, 1'b1);
    send_frame(FullNeg, 16'sd0, 1'b1);
    send_frame(16'sd0, FullPos, 1'b1);
    gapless = 1'b0;

    // Oversized buffer: the count saturates at MaxFrames and the trailing
    // frames, last one included, leave the sums alone.
    for (int unsigned i = 0; i < LongBuffer; i++) begin
      if (i % 256 == 0) gapless = ($urandom_range(0, 3) == 0);
      if (i < MaxFrames) send_frame(FullNeg, FullPos, 1'b0);
      else               send_frame(16'sd0, 16'sd0, i == LongBuffer - 1);
    end

    // Random buffers, mostly short, each ending with a last frame.
    goal = frames_sent + RandomGoal;
    while (frames_sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 10)      buf_len = 1;
      else if (roll < 75) buf_len = $urandom_range(2, 16);
      else if (roll < 97) buf_len = $urandom_range(17, 64);
      else                buf_len = $urandom_range(100, 300);
      kind_l  = sample_kind_e'($urandom_range(0, 3));
      kind_r  = sample_kind_e'($urandom_range(0, 3));
      tone_l  = SampleBits'($urandom);
      tone_r  = SampleBits'($urandom);
      gapless = ($urandom_range(0, 4) == 0);
      for (int unsigned i = 0; i < buf_len; i++) begin
        send_frame(draw_sample(kind_l, tone_l), draw_sample(kind_r, tone_r),
                   i == buf_len - 1);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/srlm_pkg.sv
rtl/srlm_in_if.sv
rtl/srlm_out_if.sv
rtl/srlm_front.sv
rtl/srlm_queue.sv
rtl/srlm_back.sv
rtl/stereo_rms_level_meter.sv
tb/srlm_level_checker.sv
tb/tb_top.sv
